FILE: hdl/npcs_pkg.sv
// shared types and constants for the nearest palette colour search block
package npcs_pkg;

   localparam logic [7:0] RB_MASK = 8'hF8;
   localparam logic [7:0] G_MASK  = 8'hFC;
   localparam int unsigned DIST_W = 18;

   typedef enum logic {
      REQ_QUERY = 1'b0,
      REQ_WRITE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic write;
      logic start;
      logic issue;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic pipe_busy;
      logic rsp_full;
   } sts_type;

endpackage

FILE: hdl/nearest_palette_color_search_top.sv
// top level of the nearest palette colour search block
//
// request channel: req_valid/req_stall with req_type and payload. a write
// request (req_type = 1) stores req_entry_color at req_entry_index and gives
// no response; slots at or above PALETTE_SIZE are ignored. a query request
// (req_type = 0) gives one response on rsp_valid/rsp_stall carrying the index
// of the nearest palette colour, lowest index on ties.
// a query walks the palette one entry per cycle through the single read port
// of the palette ram, then drains a three stage distance pipeline (ram read,
// squares, running minimum). the result is loaded into the output register
// once the pipeline has drained, and the next request can be taken in the
// same cycle the result is offered; a new query is not taken before that.
// the result sits in an output register, so a new request may be taken
// while the previous result is still stalled; a finished query waits for
// that register to be freed before it loads.
// reset is synchronous: it clears the per-slot valid bits, so every slot
// reads as black until written, and empties the pipeline and result.
module nearest_palette_color_search_top #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_query_red,
   input  logic [7:0]  req_query_green,
   input  logic [7:0]  req_query_blue,
   input  logic [7:0]  req_entry_index,
   input  logic [15:0] req_entry_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_nearest_index
);

   npcs_pkg::cmd_type cmd;
   npcs_pkg::sts_type sts;

   npcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   npcs_datapath #(
      .PALETTE_SIZE(PALETTE_SIZE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_query_red     (req_query_red),
      .req_query_green   (req_query_green),
      .req_query_blue    (req_query_blue),
      .req_entry_index   (req_entry_index),
      .req_entry_color   (req_entry_color),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_nearest_index (rsp_nearest_index)
   );

endmodule

FILE: hdl/npcs_ram.sv
// generic single write port, single read port ram with registered read
module npcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/npcs_datapath.sv
// palette store, distance pipeline, running minimum and result register
module npcs_datapath #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  npcs_pkg::cmd_type cmd,
   output npcs_pkg::sts_type sts,
   input  logic [7:0]        req_query_red,
   input  logic [7:0]        req_query_green,
   input  logic [7:0]        req_query_blue,
   input  logic [7:0]        req_entry_index,
   input  logic [15:0]       req_entry_color,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [7:0]        rsp_nearest_index
);

   localparam int IDX_W = $clog2(PALETTE_SIZE);
   localparam int DW = npcs_pkg::DIST_W;

   logic [PALETTE_SIZE-1:0] vld_ff;
   logic [IDX_W-1:0]        addr_ff;
   logic [7:0]              q_red_ff, q_green_ff, q_blue_ff;
   logic                    wr_ok;
   logic [15:0]             rd_data;

   logic                    s1_valid_ff;
   logic                    s1_vld_ff;
   logic [IDX_W-1:0]        s1_idx_ff;
   logic [15:0]             col;
   logic [7:0]              er, eg, eb, dr, dg, db;

   logic                    s2_valid_ff;
   logic [IDX_W-1:0]        s2_idx_ff;
   logic [15:0]             sq_r_ff, sq_g_ff, sq_b_ff;

   logic [DW-1:0]           dist_sum;
   logic                    first_ff;
   logic [DW-1:0]           best_ff;
   logic [IDX_W-1:0]        best_idx_ff;

   logic                    rsp_valid_ff;
   logic [7:0]              rsp_idx_ff;

   assign wr_ok = cmd.write && ({1'b0, req_entry_index} < 9'(PALETTE_SIZE));

   npcs_ram #(
      .WIDTH(16),
      .DEPTH(PALETTE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (req_entry_index[IDX_W-1:0]),
      .wr_data (req_entry_color),
      .rd_en   (cmd.issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // valid bits and scan address
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_ok) begin
         vld_ff[req_entry_index[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.start) begin
         addr_ff    <= '0;
         q_red_ff   <= req_query_red;
         q_green_ff <= req_query_green;
         q_blue_ff  <= req_query_blue;
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + 1'b1;
      end
   end

   // stage 1: ram read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
      if (cmd.issue) begin
         s1_idx_ff <= addr_ff;
         s1_vld_ff <= vld_ff[addr_ff];
      end
   end

   always_comb begin
      col = s1_vld_ff ? rd_data : 16'h0000;
      er  = col[15:8] & npcs_pkg::RB_MASK;
      eg  = col[10:3] & npcs_pkg::G_MASK;
      eb  = {col[4:0], 3'b000} & npcs_pkg::RB_MASK;
      dr  = (q_red_ff >= er) ? (q_red_ff - er) : (er - q_red_ff);
      dg  = (q_green_ff >= eg) ? (q_green_ff - eg) : (eg - q_green_ff);
      db  = (q_blue_ff >= eb) ? (q_blue_ff - eb) : (eb - q_blue_ff);
   end

   // stage 2: squares
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         s2_idx_ff <= s1_idx_ff;
         sq_r_ff   <= dr * dr;
         sq_g_ff   <= dg * dg;
         sq_b_ff   <= db * db;
      end
   end

   assign dist_sum = DW'(sq_r_ff) + DW'(sq_g_ff) + DW'(sq_b_ff);

   // stage 3: running minimum, strict compare keeps the lowest index
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else if (cmd.start) begin
         first_ff <= 1'b1;
      end else if (s2_valid_ff) begin
         first_ff <= 1'b0;
      end
      if (s2_valid_ff && (first_ff || dist_sum < best_ff)) begin
         best_ff     <= dist_sum;
         best_idx_ff <= s2_idx_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         rsp_idx_ff <= 8'(best_idx_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_idx_ff;

   assign sts.last      = (addr_ff == IDX_W'(PALETTE_SIZE - 1));
   assign sts.pipe_busy = s1_valid_ff | s2_valid_ff;
   assign sts.rsp_full  = rsp_valid_ff;

   a_load_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten before it was taken");

   a_write_not_mid_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (!s1_valid_ff && !s2_valid_ff && !cmd.issue))
      else $error("palette write during a scan");

   a_load_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!s1_valid_ff && !s2_valid_ff && !first_ff))
      else $error("result loaded before the scan drained");

endmodule

FILE: hdl/npcs_ctrl.sv
// controller state machine for request acceptance, scan and result hand-off
module npcs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_type,
   output logic              req_stall,
   input  logic              rsp_stall,
   input  npcs_pkg::sts_type sts,
   output npcs_pkg::cmd_type cmd
);

   npcs_pkg::state_type state_ff, state_in;
   logic                accept;
   logic                out_free;

   assign accept   = req_valid && (state_ff == npcs_pkg::ST_IDLE);
   assign out_free = !sts.rsp_full || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         npcs_pkg::ST_IDLE: begin
            if (accept && req_type == npcs_pkg::REQ_QUERY) begin
               state_in = npcs_pkg::ST_SCAN;
            end
         end
         npcs_pkg::ST_SCAN: begin
            if (sts.last) begin
               state_in = npcs_pkg::ST_DONE;
            end
         end
         npcs_pkg::ST_DONE: begin
            if (!sts.pipe_busy && out_free) begin
               state_in = npcs_pkg::ST_IDLE;
            end
         end
         default: state_in = npcs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         npcs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.write = accept && req_type == npcs_pkg::REQ_WRITE;
            cmd.start = accept && req_type == npcs_pkg::REQ_QUERY;
         end
         npcs_pkg::ST_SCAN: begin
            cmd.issue = 1'b1;
         end
         npcs_pkg::ST_DONE: begin
            cmd.load = !sts.pipe_busy && out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
